FILE: src/wbbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wbbf_pkg
// shared widths, codes and types for the write-back buffer with flush walk
// ----------------------------------------------------------------------------
package wbbf_pkg;

    // buffer geometry
    localparam int NUM_ADDRESSES = 128;
    localparam int ADDR_W        = $clog2(NUM_ADDRESSES);

    // field widths
    localparam int MODE_W    = 2;
    localparam int LBA_W     = 8;
    localparam int DATA_W    = 32;
    localparam int LEN_W     = 7;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    // longest erase run and largest flush threshold
    localparam int MAX_RUN = 64;

    // register reset values
    localparam logic [LEN_W-1:0] FLUSH_THRESHOLD_RST  = LEN_W'(10);
    localparam logic [LEN_W-1:0] MAX_ERASE_LENGTH_RST = LEN_W'(10);

    // command codes
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ERASE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BAD   = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NAND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ_DATA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ_REQ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INVALID    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLUSH_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERASE_LENGTH = 2'd1;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [LBA_W-1:0]     lba_t;
    typedef logic [DATA_W-1:0]    data_t;
    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [ADDR_W-1:0]    addr_t;

endpackage : wbbf_pkg
`default_nettype wire

FILE: src/write_back_buffer_flush.sv
`timescale 1ns / 1ps
`default_nettype none
// results: an invalid item or the first write of an erase shows in the cycle after accept,
// a read after the registered data ram read and then the output register
// throughput: one item at a time; an erase emits its results in order, and a flush walks
// the addresses in order, reading back and writing out each dirty entry, up to NUM_ADDRESSES
// reset: dirty marks, write count and control clear at once, no clearing pass; plus the dirty
// count; the data ram is not reset and its data is only used behind a dirty mark
// ----------------------------------------------------------------------------
// write_back_buffer_flush
// write-back buffer in front of nand storage with dirty marks and a flush walk
// ----------------------------------------------------------------------------
module write_back_buffer_flush
(
    input  wire                      clk,
    input  wire                      rst_n,
    // command items
    input  wire                      in_valid,
    output logic                     in_stall,
    input  wire  wbbf_pkg::mode_t    mode,
    input  wire  wbbf_pkg::lba_t     lba,
    input  wire  wbbf_pkg::data_t    write_data,
    input  wire  wbbf_pkg::len_t     erase_length,
    // result items
    output logic                     out_valid,
    input  wire                      out_stall,
    output wbbf_pkg::kind_t          result_kind,
    output wbbf_pkg::lba_t           out_lba,
    output wbbf_pkg::data_t          out_data,
    output logic                     last,
    // configuration writes
    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire  wbbf_pkg::cfg_idx_t cfg_index,
    input  wire  wbbf_pkg::len_t     cfg_data
);
    import wbbf_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_READ      = 3'd1;
    localparam logic [2:0] S_ERASE     = 3'd2;
    localparam logic [2:0] S_FLUSH     = 3'd3;
    localparam logic [2:0] S_FLUSH_OUT = 3'd4;

    // control state
    logic [2:0]               state_reg, state_next;
    logic [NUM_ADDRESSES-1:0] dirty_reg, dirty_next;
    len_t                     wcnt_reg, wcnt_next;     // buffered writes since last flush
    len_t                     dcnt_reg, dcnt_next;     // number of dirty entries
    len_t                     thr_reg, thr_next;
    len_t                     max_len_reg, max_len_next;
    addr_t                    idx_reg, idx_next;       // flush walk pointer
    lba_t                     cur_reg, cur_next;       // erase address / read address
    len_t                     rem_reg, rem_next;       // erase results still to go
    logic                     hit_reg, hit_next;       // read found a dirty entry

    // output register
    logic  out_valid_reg, out_valid_next;
    kind_t kind_reg, kind_next;
    lba_t  olba_reg, olba_next;
    data_t odata_reg, odata_next;
    logic  last_reg, last_next;

    // data ram
    data_t mem [NUM_ADDRESSES];
    data_t rd_data_reg;
    logic  ram_we, ram_re;
    addr_t ram_waddr, ram_raddr;

    // decode helpers
    logic  out_free;
    logic  accept;
    logic  lba_bad;
    len_t  thr_eff;
    len_t  len_lim;
    logic  len_ok;
    len_t  wcnt_inc;
    addr_t in_addr;

    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign out_lba     = olba_reg;
    assign out_data    = odata_reg;
    assign last        = last_reg;

    // the output register can take a new result when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    assign in_addr  = lba[ADDR_W-1:0];
    assign lba_bad  = ({1'b0, lba} >= (LBA_W+1)'(NUM_ADDRESSES));

    // effective threshold limited to 1..64, erase limit capped at 64
    always_comb
    begin
        if (thr_reg == '0)
            thr_eff = LEN_W'(1);
        else if (thr_reg > LEN_W'(MAX_RUN))
            thr_eff = LEN_W'(MAX_RUN);
        else
            thr_eff = thr_reg;

        if (max_len_reg > LEN_W'(MAX_RUN))
            len_lim = LEN_W'(MAX_RUN);
        else
            len_lim = max_len_reg;
    end

    assign len_ok   = (erase_length != '0) && (erase_length <= len_lim);
    assign wcnt_inc = (wcnt_reg == '1) ? wcnt_reg : wcnt_reg + LEN_W'(1);

    // main sequencer
    always_comb
    begin
        state_next     = state_reg;
        dirty_next     = dirty_reg;
        wcnt_next      = wcnt_reg;
        dcnt_next      = dcnt_reg;
        thr_next       = thr_reg;
        max_len_next   = max_len_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        rem_next       = rem_reg;
        hit_next       = hit_reg;

        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        olba_next      = olba_reg;
        odata_next     = odata_reg;
        last_next      = last_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = in_addr;
        ram_raddr = in_addr;

        // configuration writes; indexes beyond the list are dropped
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FLUSH_THRESHOLD:  thr_next     = cfg_data;
                REG_MAX_ERASE_LENGTH: max_len_next = cfg_data;
                default:              ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if ((mode == MODE_BAD) || lba_bad ||
                                 ((mode == MODE_ERASE) && !len_ok))
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_INVALID;
                        olba_next      = lba;
                        odata_next     = '0;
                        last_next      = 1'b1;
                    end
                    else if (mode == MODE_READ)
                    begin
                        // data ram read, answer from S_READ
                        ram_re     = 1'b1;
                        hit_next   = dirty_reg[in_addr];
                        cur_next   = lba;
                        state_next = S_READ;
                    end
                    else if (mode == MODE_WRITE)
                    begin
                        ram_we              = 1'b1;
                        dirty_next[in_addr] = 1'b1;
                        if (!dirty_reg[in_addr])
                            dcnt_next = dcnt_reg + LEN_W'(1);
                        wcnt_next = wcnt_inc;
                        if (wcnt_inc >= thr_eff)
                        begin
                            // threshold reached: walk the addresses up to the last dirty one
                            idx_next   = '0;
                            state_next = S_FLUSH;
                        end
                    end
                    else
                    begin
                        // erase: first zero write now, the rest from S_ERASE
                        out_valid_next = 1'b1;
                        kind_next      = KIND_NAND_WRITE;
                        olba_next      = lba;
                        odata_next     = '0;
                        last_next      = (erase_length == LEN_W'(1));
                        cur_next       = lba + LBA_W'(1);
                        rem_next       = erase_length - LEN_W'(1);
                        if (erase_length != LEN_W'(1))
                            state_next = S_ERASE;
                    end
                end
            end

            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = hit_reg ? KIND_READ_DATA : KIND_READ_REQ;
                    olba_next      = cur_reg;
                    odata_next     = hit_reg ? rd_data_reg : '0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            S_ERASE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_NAND_WRITE;
                    olba_next      = cur_reg;
                    odata_next     = '0;
                    last_next      = (rem_reg == LEN_W'(1));
                    cur_next       = cur_reg + LBA_W'(1);
                    rem_next       = rem_reg - LEN_W'(1);
                    if (rem_reg == LEN_W'(1))
                        state_next = S_IDLE;
                end
            end

            S_FLUSH:
            begin
                // one address per cycle; a dirty one is read, cleared and held in S_FLUSH_OUT until written out
                if (dirty_reg[idx_reg])
                begin
                    ram_re              = 1'b1;
                    ram_raddr           = idx_reg;
                    dirty_next[idx_reg] = 1'b0;
                    state_next          = S_FLUSH_OUT;
                end
                else
                begin
                    idx_next = idx_reg + ADDR_W'(1);
                end
            end

            S_FLUSH_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_NAND_WRITE;
                    olba_next      = LBA_W'(idx_reg);
                    odata_next     = rd_data_reg;
                    last_next      = (dcnt_reg == LEN_W'(1));
                    dcnt_next      = dcnt_reg - LEN_W'(1);
                    if (dcnt_reg == LEN_W'(1))
                    begin
                        // every dirty entry written back
                        wcnt_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_FLUSH;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dirty_reg     <= '0;
            wcnt_reg      <= '0;
            dcnt_reg      <= '0;
            thr_reg       <= FLUSH_THRESHOLD_RST;
            max_len_reg   <= MAX_ERASE_LENGTH_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dirty_reg     <= dirty_next;
            wcnt_reg      <= wcnt_next;
            dcnt_reg      <= dcnt_next;
            thr_reg       <= thr_next;
            max_len_reg   <= max_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        cur_reg   <= cur_next;
        rem_reg   <= rem_next;
        hit_reg   <= hit_next;
        kind_reg  <= kind_next;
        olba_reg  <= olba_next;
        odata_reg <= odata_next;
        last_reg  <= last_next;
    end

    // buffered data, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (ram_we)
            mem[ram_waddr] <= write_data;
        if (ram_re)
            rd_data_reg <= mem[ram_raddr];
    end

    // dirty count tracks the dirty marks; the entry waiting to be written back
    // is already clear but still counted
    a_dcnt_matches : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(dirty_reg) ==
            ((state_reg == S_FLUSH_OUT) ? 32'(dcnt_reg) - 32'd1 : 32'(dcnt_reg)))
        else $error("dirty count out of step with dirty marks");

    // the write count never passes the largest threshold
    a_wcnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
        wcnt_reg <= LEN_W'(MAX_RUN))
        else $error("write count above largest threshold");

    // a flush walk always has something left to write back
    a_flush_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH || state_reg == S_FLUSH_OUT) |-> (dcnt_reg != '0))
        else $error("flush walk with no dirty entries");

    // a flush ends with all marks clear and the count reset
    a_flush_done : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH_OUT && state_next == S_IDLE) |=>
            (dirty_reg == '0 && wcnt_reg == '0))
        else $error("flush left dirty entries behind");

    // items only enter while the sequencer is idle
    a_accept_idle : assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == S_IDLE))
        else $error("item accepted while busy");

endmodule : write_back_buffer_flush
`default_nettype wire
